@@ sv/radio_rx_frame_parser_unit_macros.svh @@
// assertion macros for the frame parser
`ifndef RADIO_RX_FRAME_PARSER_UNIT_MACROS_SVH
`define RADIO_RX_FRAME_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off during reset
`define RRFP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RRFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RRFP_ASSERT_SAME(lbl, ante, cons, msg)
`define RRFP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/rrfp_pkg.sv @@
package rrfp_pkg;

  // request codes of the input word
  localparam logic [2:0] REQ_FRAME = 3'd0;
  localparam logic [2:0] REQ_POP   = 3'd1;
  localparam logic [2:0] REQ_FLUSH = 3'd2;
  localparam logic [2:0] REQ_READ  = 3'd3;
  localparam logic [2:0] REQ_TICK  = 3'd4;
  localparam logic [2:0] REQ_CLEAR = 3'd5;

  // frame type byte codes
  localparam logic [7:0] TYPE_FLIGHT   = 8'd0;
  localparam logic [7:0] TYPE_SERIAL   = 8'd1;
  localparam logic [7:0] TYPE_DISC_REQ = 8'd2;
  localparam logic [7:0] TYPE_DISC_REP = 8'd3;

  // field widths
  localparam int REQ_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int CIDX_W  = 3;
  localparam int COUNT_W = 7;
  localparam int CHAN_W  = 16;

  // fifo fill arithmetic holds up to twice the largest depth
  localparam int FILL_W = 9;

  // silence counter limits
  localparam logic [7:0] SILENCE_RESET = 8'hFF;
  localparam logic [7:0] SILENCE_CAP   = 8'd128;
  localparam logic [7:0] PRESENT_LIMIT = 8'd32;
  localparam logic [7:0] POS_MAX       = 8'hFF;

endpackage

@@ sv/radio_rx_frame_parser_unit.sv @@
// Receive-side frame parser with receive fifo, channel store and presence counter.
// Input channel: in_valid / in_stall carry one request word (in_req_type,
//   in_byte_value, in_frame_last, in_channel_index); frame bytes, fifo pop,
//   fifo flush, channel read, presence tick and discovered-flag clear.
// Result channel: out_valid / out_stall carry exactly one result word per
//   request, in order.
// Config: cfg_wr_en with cfg_wr_data writes the device address; write it only
//   while no request is in flight.
// A request accepted at one edge shows its result word at the output
//   register after that edge. One request is accepted every cycle while
//   the receiver does not stall; the fifo memory's single write port and
//   registered read port each serve one byte per request.
// When the receiver stalls, the result word holds and in_stall rises in the
//   same cycle, so the input is held back until the word is taken.
// Reset (rst_n low at a clock edge) empties the fifo, clears committed
//   channels, the parser and the discovered flag, sets the silence counter to
//   its maximum and the device address to zero. The fifo memory itself is not
//   cleared; no clearing pass is needed, so requests are taken right away.
module radio_rx_frame_parser_unit #(
  parameter int CHANNELS     = 8,
  parameter int FIFO_DEPTH   = 128,
  parameter int HEADER_BYTES = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config port
  input  logic                                cfg_wr_en,
  input  logic [rrfp_pkg::BYTE_W-1:0]         cfg_wr_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rrfp_pkg::REQ_W-1:0]          in_req_type,
  input  logic [rrfp_pkg::BYTE_W-1:0]         in_byte_value,
  input  logic                                in_frame_last,
  input  logic [rrfp_pkg::CIDX_W-1:0]         in_channel_index,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rrfp_pkg::BYTE_W-1:0]         out_rx_data,
  output logic                                out_rx_valid,
  output logic [rrfp_pkg::COUNT_W-1:0]        out_fifo_count,
  output logic [rrfp_pkg::CHAN_W-1:0]         out_channel_value,
  output logic                                out_present,
  output logic                                out_discovered,
  output logic                                out_discover_reply_due,
  output logic                                out_command_accepted,
  output logic                                out_checksum_error
);
  import rrfp_pkg::*;

  `include "radio_rx_frame_parser_unit_macros.svh"

  localparam int AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    K_IGNORE,
    K_HEADER,
    K_CHAN,
    K_FLEN,
    K_SLEN,
    K_PAYLOAD
  } kind_t;

  // fifo pointer step with wrap at the depth
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] q;
    q = (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
    return q;
  endfunction

  // persistent state
  logic [BYTE_W-1:0] addr_r;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [7:0]        pos_r, pos_nxt;
  kind_t             kind_r, kind_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        left_r, left_nxt;
  logic              open_r, open_nxt;
  logic [7:0]        silence_r, silence_nxt;
  logic              disc_r, disc_nxt;
  logic [CHAN_W-1:0] committed_r [CHANNELS];
  logic [CHAN_W-1:0] pending_r   [CHANNELS];
  logic [BYTE_W-1:0] fifo_mem    [FIFO_DEPTH];

  // result register
  logic                out_valid_r;
  logic [BYTE_W-1:0]   res_data_r;
  logic                res_rx_valid_r;
  logic [COUNT_W-1:0]  res_count_r;
  logic [CHAN_W-1:0]   res_chan_r;
  logic                res_present_r;
  logic                res_disc_r;
  logic                res_due_r;
  logic                res_acc_r;
  logic                res_err_r;

  // per-word control
  logic              acc;
  logic              mem_we;
  logic              pop_hit;
  logic              pend_we;
  logic              pend_hi;
  logic [CH_AW-1:0]  pend_idx;
  logic              commit;
  logic              due;
  logic              cmd_ok;
  logic              cmd_err;
  logic [CHAN_W-1:0] chan_val;
  logic [COUNT_W-1:0] count_val;
  kind_t             kind_cur;
  logic [7:0]        off;
  logic [FILL_W-1:0] fill;
  logic [5:0]        ci_w;
  logic [CH_AW-1:0]  rd_idx;

  // handshake
  assign acc      = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;

  assign off    = pos_r - 8'(HEADER_BYTES + 2);
  assign ci_w   = 6'(in_channel_index);
  assign rd_idx = ci_w[CH_AW-1:0];

  // next state for one request word
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    pos_nxt     = pos_r;
    kind_nxt    = kind_r;
    sum_nxt     = sum_r;
    left_nxt    = left_r;
    open_nxt    = open_r;
    silence_nxt = silence_r;
    disc_nxt    = disc_r;
    mem_we      = 1'b0;
    pop_hit     = 1'b0;
    pend_we     = 1'b0;
    pend_hi     = off[0];
    pend_idx    = off[CH_AW:1];
    commit      = 1'b0;
    due         = 1'b0;
    cmd_ok      = 1'b0;
    cmd_err     = 1'b0;
    chan_val    = '0;
    kind_cur    = (pos_r == 8'd0) ? K_HEADER : kind_r;

    if (acc) begin
      case (in_req_type)
        REQ_FRAME: begin
          kind_nxt = kind_cur;
          case (kind_cur)
            K_HEADER: begin
              if (pos_r == 8'(HEADER_BYTES)) begin
                if (in_byte_value != addr_r) kind_nxt = K_IGNORE;
              end else if (pos_r == 8'(HEADER_BYTES + 1)) begin
                if (in_byte_value == TYPE_FLIGHT) begin
                  kind_nxt = K_CHAN;
                  sum_nxt  = '0;
                end else if (in_byte_value == TYPE_SERIAL) begin
                  kind_nxt = K_SLEN;
                end else begin
                  if (in_byte_value == TYPE_DISC_REQ) due = 1'b1;
                  else if (in_byte_value == TYPE_DISC_REP) disc_nxt = 1'b1;
                  kind_nxt = K_IGNORE;
                end
              end
            end
            K_CHAN: begin
              if (off < 8'(2 * CHANNELS)) begin
                sum_nxt = sum_r + in_byte_value;
                pend_we = 1'b1;
              end else if (in_byte_value == sum_r) begin
                commit      = 1'b1;
                silence_nxt = '0;
                cmd_ok      = 1'b1;
                kind_nxt    = K_FLEN;
              end else begin
                cmd_err  = 1'b1;
                kind_nxt = K_IGNORE;
              end
            end
            K_FLEN, K_SLEN: begin
              left_nxt = in_byte_value;
              open_nxt = (in_byte_value != 8'd0);
              kind_nxt = (in_byte_value != 8'd0) ? K_PAYLOAD : K_IGNORE;
            end
            K_PAYLOAD: begin
              if (open_r && left_r != 8'd0) begin
                if (ptr_inc(head_r) == tail_r) begin
                  // fifo full: drop the rest of the payload
                  open_nxt = 1'b0;
                  left_nxt = '0;
                  kind_nxt = K_IGNORE;
                end else begin
                  mem_we   = 1'b1;
                  head_nxt = ptr_inc(head_r);
                  left_nxt = left_r - 8'd1;
                  if (left_r == 8'd1) begin
                    open_nxt = 1'b0;
                    kind_nxt = K_IGNORE;
                  end
                end
              end else begin
                kind_nxt = K_IGNORE;
              end
            end
            default: ;
          endcase
          if (pos_r != POS_MAX) pos_nxt = pos_r + 8'd1;
          // end of frame returns the parser to the start
          if (in_frame_last) begin
            pos_nxt  = '0;
            kind_nxt = K_IGNORE;
            open_nxt = 1'b0;
            left_nxt = '0;
            sum_nxt  = '0;
          end
        end
        REQ_POP: begin
          if (head_r != tail_r) begin
            pop_hit  = 1'b1;
            tail_nxt = ptr_inc(tail_r);
          end
        end
        REQ_FLUSH: head_nxt = tail_r;
        REQ_READ: begin
          if (ci_w < 6'(CHANNELS)) chan_val = committed_r[rd_idx];
        end
        REQ_TICK: begin
          if (silence_r < SILENCE_CAP) silence_nxt = silence_r + 8'd1;
        end
        REQ_CLEAR: disc_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  // fifo fill level after the word
  always_comb begin
    if (head_nxt >= tail_nxt) begin
      fill = FILL_W'(head_nxt) - FILL_W'(tail_nxt);
    end else begin
      fill = FILL_W'(head_nxt) + FILL_W'(FIFO_DEPTH) - FILL_W'(tail_nxt);
    end
    count_val = fill[COUNT_W-1:0];
  end

  // control state and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r         <= '0;
      head_r         <= '0;
      tail_r         <= '0;
      pos_r          <= '0;
      kind_r         <= K_IGNORE;
      sum_r          <= '0;
      left_r         <= '0;
      open_r         <= 1'b0;
      silence_r      <= SILENCE_RESET;
      disc_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      res_rx_valid_r <= 1'b0;
      res_count_r    <= '0;
      res_chan_r     <= '0;
      res_present_r  <= 1'b0;
      res_disc_r     <= 1'b0;
      res_due_r      <= 1'b0;
      res_acc_r      <= 1'b0;
      res_err_r      <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) committed_r[i] <= '0;
    end else begin
      if (cfg_wr_en) addr_r <= cfg_wr_data;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      pos_r     <= pos_nxt;
      kind_r    <= kind_nxt;
      sum_r     <= sum_nxt;
      left_r    <= left_nxt;
      open_r    <= open_nxt;
      silence_r <= silence_nxt;
      disc_r    <= disc_nxt;
      if (acc) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (acc) begin
        res_rx_valid_r <= pop_hit;
        res_count_r    <= count_val;
        res_chan_r     <= chan_val;
        res_present_r  <= (silence_nxt < PRESENT_LIMIT);
        res_disc_r     <= disc_nxt;
        res_due_r      <= due;
        res_acc_r      <= cmd_ok;
        res_err_r      <= cmd_err;
      end
      if (commit) begin
        for (int i = 0; i < CHANNELS; i++) committed_r[i] <= pending_r[i];
      end
    end
  end

  // pending channel bytes
  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (pend_we && pend_idx == CH_AW'(i)) begin
        if (pend_hi) pending_r[i] <= {in_byte_value, pending_r[i][7:0]};
        else pending_r[i] <= {8'd0, in_byte_value};
      end
    end
  end

  // fifo memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) fifo_mem[head_r] <= in_byte_value;
    if (pop_hit) res_data_r <= fifo_mem[tail_r];
  end

  assign out_valid              = out_valid_r;
  assign out_rx_data            = res_rx_valid_r ? res_data_r : '0;
  assign out_rx_valid           = res_rx_valid_r;
  assign out_fifo_count         = res_count_r;
  assign out_channel_value      = res_chan_r;
  assign out_present            = res_present_r;
  assign out_discovered         = res_disc_r;
  assign out_discover_reply_due = res_due_r;
  assign out_command_accepted   = res_acc_r;
  assign out_checksum_error     = res_err_r;

  // checks
  `RRFP_ASSERT_SAME(a_pulse_excl, out_valid,
    $onehot0({out_discover_reply_due, out_command_accepted, out_checksum_error}),
    "frame pulses overlap")
  `RRFP_ASSERT_NEXT(a_rx_only_pop, in_valid && !in_stall && in_req_type != REQ_POP,
    !out_rx_valid, "rx_valid without a pop")
  `RRFP_ASSERT_SAME(a_cmd_present, out_valid && out_command_accepted, out_present,
    "accepted command left presence low")
  `RRFP_ASSERT_NEXT(a_flush_empty, in_valid && !in_stall && in_req_type == REQ_FLUSH,
    out_fifo_count == '0, "fifo not empty after flush")

endmodule
